// ----- rtl/upd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    // Characters with a special meaning in an encoded string
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Decoupling queue between classifier and decoder
    localparam int UPD_QDEPTH  = 4;
    localparam int UPD_QPTR_W  = $clog2(UPD_QDEPTH);
    localparam int UPD_QCNT_W  = $clog2(UPD_QDEPTH + 1);

    // One classified input item
    typedef struct packed {
        logic [7:0] raw;        // byte as received
        logic       is_hex;     // 0-9, A-F or a-f
        logic [3:0] hex_val;    // digit value when is_hex
        logic       is_percent;
        logic       is_plus;
        logic       last;       // final byte of the string
    } upd_class_t;

endpackage

`default_nettype wire

// ----- rtl/upd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       q_full,
    output logic            in_ready,
    output logic            push,
    output upd_class_t      push_item
);

    logic [7:0] digit;
    logic [7:0] upper;
    logic [7:0] lower;

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Classify the byte: hex digit value, percent, plus
    always_comb
    begin
        digit = in_byte - 8'h30;
        upper = in_byte - 8'h37;
        lower = in_byte - 8'h57;
        push_item            = '0;
        push_item.raw        = in_byte;
        push_item.last       = in_last;
        push_item.is_percent = (in_byte == CH_PERCENT);
        push_item.is_plus    = (in_byte == CH_PLUS);
        if (in_byte inside {[8'h30:8'h39]})
        begin
            push_item.is_hex  = 1'b1;
            push_item.hex_val = digit[3:0];
        end
        else if (in_byte inside {[8'h41:8'h46]})
        begin
            push_item.is_hex  = 1'b1;
            push_item.hex_val = upper[3:0];
        end
        else if (in_byte inside {[8'h61:8'h66]})
        begin
            push_item.is_hex  = 1'b1;
            push_item.hex_val = lower[3:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  upd_class_t      push_item,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output upd_class_t      head_item
);

    upd_class_t              slot_reg [UPD_QDEPTH];
    logic [UPD_QPTR_W-1:0]   wr_ptr_reg;
    logic [UPD_QPTR_W-1:0]   wr_ptr_next;
    logic [UPD_QPTR_W-1:0]   rd_ptr_reg;
    logic [UPD_QPTR_W-1:0]   rd_ptr_next;
    logic [UPD_QCNT_W-1:0]   count_reg;
    logic [UPD_QCNT_W-1:0]   count_next;

    assign full       = (count_reg == UPD_QCNT_W'(UPD_QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == UPD_QPTR_W'(UPD_QDEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == UPD_QPTR_W'(UPD_QDEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  upd_class_t      head_item,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            end_of_string,
    output logic            bad_encoding
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  nibble_reg;
    logic [3:0]  nibble_next;
    logic        error_reg;
    logic        error_next;

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        bvalid_reg;
    logic        bvalid_next;
    logic        eos_reg;
    logic        eos_next;
    logic        bad_reg;
    logic        bad_next;

    logic        have;
    logic [7:0]  val;
    logic        bad;

    // Take the next item when the output register is free or draining
    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        error_next  = error_reg;
        valid_next  = valid_reg && !out_ready;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        eos_next    = eos_reg;
        bad_next    = bad_reg;
        have        = 1'b0;
        val         = '0;
        bad         = 1'b0;

        if (pop)
        begin
            // Step the escape state unless the string already failed
            if (!error_reg)
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (head_item.is_hex)
                        begin
                            nibble_next = head_item.hex_val;
                            phase_next  = PH_LOW;
                        end
                        else
                        begin
                            error_next = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_LOW:
                    begin
                        if (head_item.is_hex)
                        begin
                            val  = {nibble_reg, head_item.hex_val};
                            have = 1'b1;
                        end
                        else
                        begin
                            error_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (head_item.is_percent)
                        begin
                            phase_next = PH_HIGH;
                        end
                        else if (head_item.is_plus)
                        begin
                            val  = CH_SPACE;
                            have = 1'b1;
                        end
                        else
                        begin
                            val  = head_item.raw;
                            have = 1'b1;
                        end
                    end
                endcase
            end

            if (head_item.last)
            begin
                // End of string: always report, then clear the state
                bad         = error_next || (phase_next != PH_IDLE);
                valid_next  = 1'b1;
                byte_next   = (have && !bad) ? val : 8'h00;
                bvalid_next = have && !bad;
                eos_next    = 1'b1;
                bad_next    = bad;
                phase_next  = PH_IDLE;
                nibble_next = '0;
                error_next  = 1'b0;
            end
            else if (have)
            begin
                valid_next  = 1'b1;
                byte_next   = val;
                bvalid_next = 1'b1;
                eos_next    = 1'b0;
                bad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            nibble_reg <= '0;
            error_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            byte_reg   <= '0;
            bvalid_reg <= 1'b0;
            eos_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            error_reg  <= error_next;
            valid_reg  <= valid_next;
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            eos_reg    <= eos_next;
            bad_reg    <= bad_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign byte_valid    = bvalid_reg;
    assign end_of_string = eos_reg;
    assign bad_encoding  = bad_reg;

endmodule

`default_nettype wire

// ----- rtl/url_percent_decoder.sv -----
// URL percent decoder, one byte per item.
// Input stream (s_axis): tdata carries one byte of the encoded string,
// tlast marks the final byte of the string.
// Output stream (m_axis): tdata carries the decoded byte, tuser[0] says
// the byte is meaningful, tuser[1] flags a malformed string, and tlast
// marks the result for the final input byte. Plus becomes a space and a
// percent with two hex digits becomes one byte, so escape bytes give no
// result except at the end of a string, which always gives exactly one.
// A flagged string must be discarded downstream.
// Throughput: one byte per cycle while the receiver is ready. An accepted
// item is classified into a 4-entry queue, then decoded against the escape
// state into the output register.
// Reset clears the queue, the escape state and the output register.
// When the receiver stalls the output holds, the decoder stops popping,
// and the queue absorbs up to four items before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] bad_encoding
    output logic            m_axis_tlast
);

    logic       q_full;
    logic       push;
    upd_class_t push_item;
    logic       pop;
    logic       head_valid;
    upd_class_t head_item;
    logic       byte_valid;
    logic       bad_encoding;

    upd_front u_front (
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_item (push_item)
    );

    upd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    upd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .byte_valid    (byte_valid),
        .end_of_string (m_axis_tlast),
        .bad_encoding  (bad_encoding)
    );

    assign m_axis_tuser = {bad_encoding, byte_valid};

    // A flagged string never carries a decoded byte on its end result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("bad string carries a decoded byte");

    // The error flag only appears on the end of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("error flag before end of string");

    // Results inside a string always carry a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
        else $error("empty result inside a string");

    // The decoder never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
